[rtl/isrt_pkg.sv]
package isrt_pkg;

  localparam int unsigned KEY_W = 32;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic                    batch_end;
  } isrt_in_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] sorted_key;
    logic                    final_res;
    logic                    overflowed;
  } isrt_out_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } isrt_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic shift;
  } isrt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last_one;
  } isrt_status_t;

endpackage

[rtl/isrt_ctrl.sv]
module isrt_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  batch_end,
  input  isrt_pkg::isrt_status_t status,
  output isrt_pkg::isrt_cmd_t    cmd,
  output logic                  busy
);
  import isrt_pkg::*;

  isrt_state_t state_r;
  isrt_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.load  = 1'b0;
    cmd.shift = 1'b0;
    busy      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (batch_end) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        busy      = 1'b1;
        cmd.shift = 1'b1;
        if (status.last_one) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load && cmd.shift))
    else $error("load and shift issued together");

  a_emit_ends: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift && status.last_one |=> state_r == ST_IDLE)
    else $error("emission did not end after last key");

  a_batch_emits: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load && batch_end |=> cmd.shift)
    else $error("batch end not followed by emission");

endmodule

[rtl/isrt_datapath.sv]
module isrt_datapath #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  isrt_pkg::isrt_cmd_t             cmd,
  input  logic signed [isrt_pkg::KEY_W-1:0] in_key,
  output isrt_pkg::isrt_status_t          status,
  output logic                           out_valid,
  output isrt_pkg::isrt_out_t             out_data
);
  import isrt_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic signed [KEY_W-1:0] cell_r   [CAPACITY];
  logic signed [KEY_W-1:0] cell_nxt [CAPACITY];
  logic [CAPACITY-1:0]     gt;
  logic [CNT_W-1:0]        fill_r;
  logic                    drop_r;
  logic                    full;
  logic                    valid_r;
  logic signed [KEY_W-1:0] key_r;
  logic                    final_r;
  logic                    ovf_r;

  assign full            = (fill_r == CNT_W'(CAPACITY));
  assign status.last_one = (fill_r == CNT_W'(1));

  // empty cells count as greater, so the key lands in the first greater cell
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      gt[i] = (CNT_W'(i) >= fill_r) || (cell_r[i] > in_key);
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (cmd.shift) begin
        cell_nxt[i] = (i < CAPACITY - 1) ? cell_r[(i < CAPACITY - 1) ? i + 1 : i] : cell_r[i];
      end else if (cmd.load && !full && gt[i]) begin
        if (i == 0) begin
          cell_nxt[i] = in_key;
        end else if (!gt[(i > 0) ? i - 1 : 0]) begin
          cell_nxt[i] = in_key;
        end else begin
          cell_nxt[i] = cell_r[(i > 0) ? i - 1 : 0];
        end
      end else begin
        cell_nxt[i] = cell_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_r[i] <= cell_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      drop_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.shift;
      if (cmd.shift) begin
        fill_r <= fill_r - CNT_W'(1);
        if (status.last_one) begin
          drop_r <= 1'b0;
        end
      end else if (cmd.load) begin
        if (full) begin
          drop_r <= 1'b1;
        end else begin
          fill_r <= fill_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      key_r   <= cell_r[0];
      final_r <= status.last_one;
      ovf_r   <= drop_r;
    end
  end

  assign out_valid           = valid_r;
  assign out_data.sorted_key = key_r;
  assign out_data.final_res  = final_r;
  assign out_data.overflowed = ovf_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(CAPACITY))
    else $error("fill count beyond capacity");

  a_shift_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift |-> fill_r != '0)
    else $error("emission from an empty store");

  a_final_empties: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && final_r |-> fill_r == '0 && !drop_r)
    else $error("store not emptied after final result");

  a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !final_r |=> valid_r && (key_r >= $past(key_r)))
    else $error("results out of order");

endmodule

[rtl/insertion_sorter.sv]
// Channel  Ports                          Transaction
// input    start, busy, in_data           start high while busy low
// result   out_valid, out_data            out_valid high, one cycle, no stall
//
// An unflagged key is inserted: every cell compares against it at once and
// the row of cells shifts right from the insertion point.
// A flagged key is stored the same way, then busy stays high while the N
// stored keys shift out of cell 0, one per cycle; start is taken again as the
// last result shows. Reset (rst_n, synchronous) empties the store and clears
// the overflow flag. Results cannot be held off by the receiver.
module insertion_sorter #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  isrt_pkg::isrt_in_t  in_data,
  output logic               out_valid,
  output isrt_pkg::isrt_out_t out_data
);
  import isrt_pkg::*;

  isrt_cmd_t    cmd;
  isrt_status_t status;

  isrt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .batch_end (in_data.batch_end),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy)
  );

  isrt_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_key    (in_data.key),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
